>>> sv/sca_pkg.sv
// Package: result kinds, special scancodes and the key translation tables.
package sca_pkg;

    localparam int unsigned TableLen = 84;

    // Result kinds
    localparam logic [1:0] KIND_RAW   = 2'd0;
    localparam logic [1:0] KIND_CHAR  = 2'd1;
    localparam logic [1:0] KIND_ARROW = 2'd2;

    // Arrow codes
    localparam logic [7:0] ARROW_NONE  = 8'd0;
    localparam logic [7:0] ARROW_LEFT  = 8'd1;
    localparam logic [7:0] ARROW_RIGHT = 8'd2;
    localparam logic [7:0] ARROW_UP    = 8'd3;
    localparam logic [7:0] ARROW_DOWN  = 8'd4;

    // Special scancodes
    localparam logic [7:0] SC_PREFIX     = 8'hE0;
    localparam logic [7:0] SC_DELETE     = 8'h53;
    localparam logic [7:0] SC_LSHIFT     = 8'h2A;
    localparam logic [7:0] SC_RSHIFT     = 8'h36;
    localparam logic [7:0] SC_LSHIFT_REL = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_REL = 8'hB6;
    localparam logic [7:0] SC_CTRL       = 8'h1D;
    localparam logic [7:0] SC_CTRL_REL   = 8'h9D;
    localparam logic [7:0] SC_CAPS       = 8'h3A;
    localparam logic [6:0] SC_ESC_BASE   = 7'h01;
    localparam logic [6:0] SC_LEFT       = 7'h4B;
    localparam logic [6:0] SC_RIGHT      = 7'h4D;
    localparam logic [6:0] SC_UP         = 7'h48;
    localparam logic [6:0] SC_DOWN       = 7'h50;
    localparam logic [6:0] SC_TABLE_END  = 7'h53;

    localparam logic [7:0] CH_ESC     = 8'd27;
    localparam logic [7:0] CH_DEL     = 8'h7F;
    localparam logic [7:0] CASE_DELTA = 8'h20;
    localparam logic [7:0] CTRL_LOWER = 8'h60;
    localparam logic [7:0] CTRL_UPPER = 8'h40;

    // Register indexes
    localparam logic [1:0] REG_LAYOUT    = 2'd0;
    localparam logic [1:0] REG_BRK_EN    = 2'd1;
    localparam logic [1:0] REG_BRK_CODE  = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] code;
        logic       down;
        logic       brk;
    } t_result;

    localparam logic [7:0] LOW_US [TableLen] = '{
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h37, 8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E
    };

    localparam logic [7:0] UP_US [TableLen] = '{
        8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
        8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
        8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
        8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h37, 8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E
    };

    localparam logic [7:0] LOW_TR [TableLen] = '{
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2A, 8'h2D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'hFD, 8'h6F, 8'h70, 8'hF0, 8'hFC, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'hFE,
        8'h69, 8'h2C, 8'h00, 8'h3B, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'hF6, 8'hE7, 8'h2E, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h37, 8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E
    };

    localparam logic [7:0] UP_TR [TableLen] = '{
        8'h00, 8'h00, 8'h21, 8'h22, 8'h5E, 8'h2B, 8'h25, 8'h26, 8'h2F, 8'h28,
        8'h29, 8'h3D, 8'h3F, 8'h5F, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
        8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'hD0, 8'hDC, 8'h0A, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'hDE,
        8'hDD, 8'h3B, 8'h00, 8'h3A, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
        8'h4D, 8'hD6, 8'hC7, 8'h2E, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h37, 8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E
    };

    function automatic logic [7:0] arrow_of(input logic [6:0] base);
        logic [7:0] a;
        case (base)
            SC_LEFT:  a = ARROW_LEFT;
            SC_RIGHT: a = ARROW_RIGHT;
            SC_UP:    a = ARROW_UP;
            SC_DOWN:  a = ARROW_DOWN;
            default:  a = ARROW_NONE;
        endcase
        return a;
    endfunction

endpackage

>>> sv/scancode_to_ascii_decoder.sv
// Top level: set-1 scancode decoder with APB register port.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------------
//  scan in | in        | i_valid / o_ready | i_scan_code
//  result  | out       | o_valid / i_ready | o_result_kind, o_key_code, o_key_down,
//          |           |                   | o_break_match, o_shift_state,
//          |           |                   | o_ctrl_state, o_last_of_run
//  config  | in        | psel / penable    | pwrite, paddr, pwdata, prdata, pready
//
// Each accepted byte is held in the input register, then is decoded in one pass
// into a two-entry result buffer. One result beat leaves per cycle while i_ready
// is high; the next byte moves on only as the last pending result leaves, so
// the result buffer's drain sets the pace.
// Reset (synchronous, active low) clears the decoder state, registers and valids.
// A stalled result keeps the next byte in the input register; input stalls only
// when that register is full and cannot move on.
module scancode_to_ascii_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // scancode channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_scan_code,
    // result channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_result_kind,
    output logic [7:0] o_key_code,
    output logic       o_key_down,
    output logic       o_break_match,
    output logic       o_shift_state,
    output logic       o_ctrl_state,
    output logic       o_last_of_run,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sca_pkg::*;

    // config registers
    logic       r_layout;
    logic       r_brk_en;
    logic [7:0] r_brk_code;

    // decoder state
    logic r_prefix;
    logic r_shift_down;
    logic r_ctrl_down;
    logic r_caps_on;

    // input register
    logic       r_s1_valid;
    logic [7:0] r_code;

    // result buffer: entry 0 is always the head
    t_result    r_res [2];
    logic [1:0] r_cnt;

    logic pop;
    logic move;
    logic cfg_wr;

    // decode outputs
    logic       n_prefix;
    logic       n_shift_down;
    logic       n_ctrl_down;
    logic       n_caps_on;
    t_result    res_a;
    t_result    res_b;
    logic       a_vld;
    logic       b_vld;

    logic [6:0] base;
    logic       rel;
    logic [6:0] tidx;
    logic [7:0] lo_byte;
    logic [7:0] hi_byte;
    logic [7:0] raw;
    logic [7:0] arrow;
    logic [7:0] key;
    logic [7:0] key_case;

    assign pop    = o_valid && i_ready;
    assign move   = r_s1_valid && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop));
    assign o_ready = !r_s1_valid || move;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        case (paddr[3:2])
            REG_LAYOUT:   prdata = {31'd0, r_layout};
            REG_BRK_EN:   prdata = {31'd0, r_brk_en};
            REG_BRK_CODE: prdata = {24'd0, r_brk_code};
            default:      prdata = 32'd0;
        endcase
    end

    // table lookups, index kept in range
    assign base    = r_code[6:0];
    assign rel     = r_code[7];
    assign tidx    = (base < SC_TABLE_END) ? base : 7'd0;
    assign lo_byte = r_layout ? LOW_TR[tidx] : LOW_US[tidx];
    assign hi_byte = r_layout ? UP_TR[tidx]  : UP_US[tidx];
    assign arrow   = arrow_of(base);

    always_comb begin
        n_prefix     = r_prefix;
        n_shift_down = r_shift_down;
        n_ctrl_down  = r_ctrl_down;
        n_caps_on    = r_caps_on;
        res_a        = '0;
        res_b        = '0;
        a_vld        = 1'b0;
        b_vld        = 1'b0;
        raw          = 8'd0;
        key          = 8'd0;
        key_case     = 8'd0;

        if (r_code == SC_PREFIX) begin
            n_prefix = 1'b1;
        end else if (r_prefix) begin
            n_prefix = 1'b0;
            if (r_code == SC_DELETE) begin
                a_vld = 1'b1;
                res_a = '{kind: KIND_CHAR, code: CH_DEL, down: 1'b1, brk: 1'b0};
            end else if (arrow != ARROW_NONE) begin
                a_vld = 1'b1;
                res_a = '{kind: KIND_RAW, code: arrow, down: !rel, brk: 1'b0};
                b_vld = !rel;
                res_b = '{kind: KIND_ARROW, code: arrow, down: 1'b1, brk: 1'b0};
            end
        end else if (r_code == SC_LSHIFT || r_code == SC_RSHIFT) begin
            n_shift_down = 1'b1;
        end else if (r_code == SC_LSHIFT_REL || r_code == SC_RSHIFT_REL) begin
            n_shift_down = 1'b0;
        end else if (r_code == SC_CTRL) begin
            n_ctrl_down = 1'b1;
        end else if (r_code == SC_CTRL_REL) begin
            n_ctrl_down = 1'b0;
        end else if (r_code == SC_CAPS) begin
            n_caps_on = !r_caps_on;
        end else begin
            if (base == SC_ESC_BASE) begin
                raw = CH_ESC;
            end else if (base < SC_TABLE_END) begin
                raw = lo_byte;
            end
            a_vld = (raw != 8'd0);
            res_a = '{kind: KIND_RAW, code: raw, down: !rel, brk: 1'b0};

            if (!rel) begin
                if (arrow != ARROW_NONE) begin
                    b_vld = 1'b1;
                    res_b = '{kind: KIND_ARROW, code: arrow, down: 1'b1, brk: 1'b0};
                end else begin
                    if (base < SC_TABLE_END) begin
                        key = r_shift_down ? hi_byte : lo_byte;
                    end
                    // caps swaps case only without ctrl
                    key_case = key;
                    if (r_caps_on && !r_ctrl_down) begin
                        if (key >= "a" && key <= "z") begin
                            key_case = key - CASE_DELTA;
                        end else if (key >= "A" && key <= "Z") begin
                            key_case = key + CASE_DELTA;
                        end
                    end
                    if (r_ctrl_down) begin
                        if (key >= "a" && key <= "z") begin
                            key_case = key - CTRL_LOWER;
                        end else if (key >= "A" && key <= "Z") begin
                            key_case = key - CTRL_UPPER;
                        end
                    end
                    b_vld = (key_case != 8'd0);
                    res_b = '{kind: KIND_CHAR, code: key_case, down: 1'b1,
                              brk: r_brk_en && (key_case == r_brk_code)};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout     <= 1'b0;
            r_brk_en     <= 1'b0;
            r_brk_code   <= 8'd0;
            r_prefix     <= 1'b0;
            r_shift_down <= 1'b0;
            r_ctrl_down  <= 1'b0;
            r_caps_on    <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_cnt        <= 2'd0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_LAYOUT:   r_layout   <= pwdata[0];
                    REG_BRK_EN:   r_brk_en   <= pwdata[0];
                    REG_BRK_CODE: r_brk_code <= pwdata[7:0];
                    default:      ;
                endcase
            end

            if (o_ready && i_valid) begin
                r_s1_valid <= 1'b1;
            end else if (move) begin
                r_s1_valid <= 1'b0;
            end

            if (move) begin
                r_prefix     <= n_prefix;
                r_shift_down <= n_shift_down;
                r_ctrl_down  <= n_ctrl_down;
                r_caps_on    <= n_caps_on;
                r_cnt        <= {1'b0, a_vld} + {1'b0, b_vld};
            end else if (pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_code <= i_scan_code;
        end
        if (move) begin
            r_res[0] <= a_vld ? res_a : res_b;
            r_res[1] <= res_b;
        end else if (pop) begin
            r_res[0] <= r_res[1];
        end
    end

    assign o_valid       = (r_cnt != 2'd0);
    assign o_result_kind = r_res[0].kind;
    assign o_key_code    = r_res[0].code;
    assign o_key_down    = r_res[0].down;
    assign o_break_match = r_res[0].brk;
    assign o_shift_state = r_shift_down;
    assign o_ctrl_state  = r_ctrl_down;
    assign o_last_of_run = (r_cnt == 2'd1);

    // buffer never holds more than two results
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result buffer overfilled");

    // a prefix byte yields no beat
    a_prefix_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move && (r_code == SC_PREFIX) |=> (r_cnt == 2'd0) && r_prefix)
        else $error("prefix byte produced a result");

    // modifier state holds while results of a byte are still pending
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd0) && !pop |=> $stable(r_shift_down) && $stable(r_ctrl_down))
        else $error("modifier state changed under pending results");

    // arrow beats carry codes 1 to 4 only
    a_arrow_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result_kind == KIND_ARROW) |->
            (o_key_code == ARROW_LEFT) || (o_key_code == ARROW_RIGHT) ||
            (o_key_code == ARROW_UP) || (o_key_code == ARROW_DOWN))
        else $error("bad arrow code");

    // only character beats may flag the break match
    a_brk_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_break_match |-> (o_result_kind == KIND_CHAR) && o_key_down)
        else $error("break match on a non-character beat");

endmodule
